### design/pfe_pkg.sv
package pfe_pkg;

    localparam int STACK_DEPTH_DEF = 128;
    localparam int WORD_W          = 32;
    localparam int DIV_STEPS       = WORD_W;

    localparam logic [7:0] SYM_ZERO  = 8'd48;
    localparam logic [7:0] SYM_PLUS  = 8'd43;
    localparam logic [7:0] SYM_MINUS = 8'd45;
    localparam logic [7:0] SYM_TIMES = 8'd42;
    localparam logic [7:0] SYM_SLASH = 8'd47;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_UNDER = 2'd1;
    localparam logic [1:0] ERR_OVER  = 2'd2;
    localparam logic [1:0] ERR_DIVZ  = 2'd3;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last_symbol;
    } in_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic [1:0]               status;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_PUSH,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } op_kind_t;

    // Classified command handed from the front to the back
    typedef struct packed {
        op_kind_t          kind;
        logic [WORD_W-1:0] word;
        logic              last;
    } cmd_t;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] num;
        logic [WORD_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quot;
    } div_rsp_t;

endpackage

### design/pfe_front.sv
module pfe_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  pfe_pkg::in_item_t item,
    output logic              cmd_valid,
    output pfe_pkg::cmd_t     cmd,
    input  logic              cmd_take
);
    import pfe_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       accept;
    logic       take;
    cmd_t       classified;

    // Decode the character into an operation and its operand word
    always_comb
    begin
        classified.last = item.last_symbol;
        classified.word = {24'd0, item.symbol} - {24'd0, SYM_ZERO};
        case (item.symbol)
            SYM_PLUS:  classified.kind = OP_ADD;
            SYM_MINUS: classified.kind = OP_SUB;
            SYM_TIMES: classified.kind = OP_MUL;
            SYM_SLASH: classified.kind = OP_DIV;
            default:   classified.kind = OP_PUSH;
        endcase
    end

    assign full      = (fill_reg == 2'd2);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign accept    = push && !full;
    assign take      = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = accept ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, accept} - {1'b0, take};
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wr_ptr_reg] <= classified;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

### design/pfe_div.sv
module pfe_div (
    input  logic              clk,
    input  logic              rst_n,
    input  pfe_pkg::div_req_t req,
    output pfe_pkg::div_rsp_t rsp
);
    import pfe_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] rem_next;
    logic [WORD_W-1:0] quo_reg;
    logic [WORD_W-1:0] quo_next;
    logic [WORD_W-1:0] den_reg;
    logic [WORD_W-1:0] den_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   trial;

    // Restoring division, one quotient bit per cycle
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[WORD_W-1]};
        trial     = shifted - {1'b0, den_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.num;
            den_next  = req.den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[WORD_W])
            begin
                rem_next = shifted[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule

### design/pfe_back.sv
module pfe_back #(
    parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  pfe_pkg::cmd_t      cmd,
    output logic               cmd_take,
    output pfe_pkg::div_req_t  div_req,
    input  pfe_pkg::div_rsp_t  div_rsp,
    output logic               empty,
    input  logic               pop,
    output pfe_pkg::out_item_t result
);
    import pfe_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_OPER,
        S_DIV,
        S_EMIT
    } state_t;

    // Words below the top of stack; the top itself lives in tos_reg
    logic [WORD_W-1:0] mem [STACK_DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;

    state_t            state_reg;
    state_t            state_next;
    logic [WORD_W-1:0] tos_reg;
    logic [WORD_W-1:0] tos_next;
    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     cnt_next;
    logic [1:0]        err_reg;
    logic [1:0]        err_next;
    op_kind_t          kind_reg;
    op_kind_t          kind_next;
    logic              last_reg;
    logic              last_next;
    logic              neg_reg;
    logic              neg_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_item_t         out_reg;
    out_item_t         out_next;

    logic [WORD_W-1:0] rhs;
    logic [WORD_W-1:0] lhs;
    logic [WORD_W-1:0] rhs_mag;
    logic [WORD_W-1:0] lhs_mag;
    logic              under;
    logic [1:0]        err_pop;
    logic [CW-1:0]     cnt_after;
    logic              slot_free;

    assign wr_addr = AW'(cnt_reg - CW'(1));
    assign rd_addr = AW'(cnt_reg - CW'(2));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= tos_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Operand fetch for a binary operator: right from the top, left from memory
    always_comb
    begin
        under     = (cnt_reg < CW'(2));
        rhs       = (cnt_reg != '0) ? tos_reg : '0;
        lhs       = under ? '0 : rd_data_reg;
        err_pop   = (err_reg != ERR_NONE) ? err_reg : (under ? ERR_UNDER : ERR_NONE);
        cnt_after = under ? CW'(1) : (cnt_reg - CW'(1));
        rhs_mag   = rhs[WORD_W-1] ? (~rhs + 1'b1) : rhs;
        lhs_mag   = lhs[WORD_W-1] ? (~lhs + 1'b1) : lhs;
        slot_free = !out_valid_reg || pop;
    end

    always_comb
    begin
        state_next     = state_reg;
        tos_next       = tos_reg;
        cnt_next       = cnt_reg;
        err_next       = err_reg;
        kind_next      = kind_reg;
        last_next      = last_reg;
        neg_next       = neg_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        cmd_take       = 1'b0;
        wr_en          = 1'b0;
        div_req.start  = 1'b0;
        div_req.num    = lhs_mag;
        div_req.den    = rhs_mag;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take  = 1'b1;
                    kind_next = cmd.kind;
                    last_next = cmd.last;
                    if (cmd.kind == OP_PUSH)
                    begin
                        if (cnt_reg == CW'(STACK_DEPTH))
                        begin
                            if (err_reg == ERR_NONE)
                            begin
                                err_next = ERR_OVER;
                            end
                        end
                        else
                        begin
                            wr_en    = (cnt_reg != '0);
                            tos_next = cmd.word;
                            cnt_next = cnt_reg + 1'b1;
                        end
                        state_next = cmd.last ? S_EMIT : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_OPER;
                    end
                end
            end
            S_OPER:
            begin
                cnt_next   = cnt_after;
                err_next   = err_pop;
                state_next = last_reg ? S_EMIT : S_IDLE;
                case (kind_reg)
                    OP_ADD: tos_next = lhs + rhs;
                    OP_SUB: tos_next = lhs - rhs;
                    OP_MUL: tos_next = lhs * rhs;
                    OP_DIV:
                    begin
                        if (rhs == '0)
                        begin
                            tos_next = '0;
                            if (err_pop == ERR_NONE)
                            begin
                                err_next = ERR_DIVZ;
                            end
                        end
                        else
                        begin
                            div_req.start = 1'b1;
                            neg_next      = lhs[WORD_W-1] ^ rhs[WORD_W-1];
                            state_next    = S_DIV;
                        end
                    end
                    default: tos_next = tos_reg;
                endcase
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    tos_next   = neg_reg ? (~div_rsp.quot + 1'b1) : div_rsp.quot;
                    state_next = last_reg ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_next.value  = (cnt_reg == '0) ? '0 : tos_reg;
                    out_next.status = (err_reg != ERR_NONE) ? err_reg :
                                      ((cnt_reg == '0) ? ERR_UNDER : ERR_NONE);
                    out_valid_next  = 1'b1;
                    cnt_next        = '0;
                    err_next        = ERR_NONE;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
            tos_reg       <= '0;
            kind_reg      <= OP_PUSH;
            last_reg      <= 1'b0;
            neg_reg       <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
            tos_reg       <= tos_next;
            kind_reg      <= kind_next;
            last_reg      <= last_next;
            neg_reg       <= neg_next;
            out_reg       <= out_next;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

endmodule

### design/postfix_expression_evaluator_top.sv
// An operand is taken by the back in S_IDLE and put on the stack; + - * go on to S_OPER
// (operand fetch, then the result), / on from S_OPER to S_DIV (a 32-step restoring divider).
// A character marked last then passes through S_EMIT into the result register.
// Operands not marked last are taken one character per cycle; + - * hold the back in
// S_OPER, / in S_OPER and S_DIV, a result left waiting in S_EMIT; the input fills behind it.
// Reset: rst_n clears the queues, stack count and error code; stack memory words are left as is.
module postfix_expression_evaluator_top #(
    parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  pfe_pkg::in_item_t  item,
    output logic               empty,
    input  logic               pop,
    output pfe_pkg::out_item_t result
);
    import pfe_pkg::*;

    // Classified commands between the front and the back
    logic     cmd_valid;
    logic     cmd_take;
    cmd_t     cmd;

    // Divider handshake: start pulse in, done pulse with quotient out
    div_req_t div_req;
    div_rsp_t div_rsp;

    // Front: decode each character and hold it in a two-entry queue so
    // the input side keeps moving while the back is busy
    pfe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    // Back: run the stack, the arithmetic and the result register
    pfe_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    // Iterative divider on magnitudes, used by the back, which applies the sign
    pfe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import pfe_pkg::*;

    localparam int DEPTH         = STACK_DEPTH_DEF;
    localparam int MAX_REPORTS   = 10;
    localparam int DRAIN_CYCLES  = 64;
    localparam int TIMEOUT_NS    = 10_000_000;
    // 128 as an operand byte: 176 - 48; four of them multiplied give 2^28
    localparam logic [7:0] BIG_OPERAND = 8'd176;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    in_item_t  item = '0;
    logic      empty;
    logic      pop = 1'b0;
    out_item_t result;

    // Stack mirror used to predict every expression value and status
    logic [31:0] mirror_stack [DEPTH];
    int unsigned mirror_count = 0;
    logic [1:0]  mirror_error = ERR_NONE;
    out_item_t   pending_results [$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_left     = 0;
    int unsigned symbols_sent  = 0;
    int unsigned results_seen  = 0;
    int unsigned fault_count   = 0;
    int unsigned stall_cycles  = 0;
    int unsigned status_tally [4] = '{0, 0, 0, 0};

    postfix_expression_evaluator_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic logic is_operator(logic [7:0] sym);
        return sym == SYM_PLUS || sym == SYM_MINUS || sym == SYM_TIMES || sym == SYM_SLASH;
    endfunction

    // Keep only the first error of an expression
    function automatic void record_error(logic [1:0] code);
        if (mirror_error == ERR_NONE)
            mirror_error = code;
    endfunction

    // A push onto a full stack is dropped
    function automatic void push_word(logic [31:0] word);
        if (mirror_count >= DEPTH)
            record_error(ERR_OVER);
        else
        begin
            mirror_stack[mirror_count] = word;
            mirror_count++;
        end
    endfunction

    // A pop from an empty stack yields zero
    function automatic logic [31:0] pop_word();
        if (mirror_count == 0)
        begin
            record_error(ERR_UNDER);
            return '0;
        end
        mirror_count--;
        return mirror_stack[mirror_count];
    endfunction

    // Truncate toward zero on magnitudes; the most negative word over minus one wraps
    function automatic logic [31:0] truncated_quotient(logic [31:0] num, logic [31:0] den);
        logic [31:0] num_mag;
        logic [31:0] den_mag;
        logic [31:0] quot;
        num_mag = num[31] ? -num : num;
        den_mag = den[31] ? -den : den;
        quot    = num_mag / den_mag;
        return (num[31] != den[31]) ? -quot : quot;
    endfunction

    function automatic void evaluate_symbol(in_item_t it);
        logic [31:0] rhs;
        logic [31:0] lhs;
        logic [31:0] res;
        out_item_t   outcome;
        if (is_operator(it.symbol))
        begin
            rhs = pop_word();
            lhs = pop_word();
            case (it.symbol)
                SYM_PLUS:  res = lhs + rhs;
                SYM_MINUS: res = lhs - rhs;
                SYM_TIMES: res = lhs * rhs;
                default:
                begin
                    if (rhs == '0)
                    begin
                        record_error(ERR_DIVZ);
                        res = '0;
                    end
                    else
                        res = truncated_quotient(lhs, rhs);
                end
            endcase
            push_word(res);
        end
        else
            push_word({24'd0, it.symbol} - {24'd0, SYM_ZERO});

        if (it.last_symbol)
        begin
            outcome.value  = pop_word();
            outcome.status = mirror_error;
            pending_results.push_back(outcome);
            mirror_count = 0;
            mirror_error = ERR_NONE;
        end
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Offer one character; return once the block has taken the transaction
    task automatic send_symbol(input logic [7:0] sym, input logic fin);
        in_item_t it;
        it.symbol      = sym;
        it.last_symbol = fin;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
        begin
            stall_cycles++;
            @(posedge clk);
        end
        evaluate_symbol(it);
        symbols_sent++;
    endtask

    // Send a whole expression written as text, marking its final character
    task automatic send_characters(input string text);
        for (int i = 0; i < text.len(); i++)
            send_symbol(text[i], i == text.len() - 1);
    endtask

    // Drop push, wait for every outstanding result, then let the pipeline settle
    task automatic drain_results();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] random_operand();
        logic [7:0] sym;
        if ($urandom_range(99) < 70)
            return SYM_ZERO + 8'($urandom_range(9));
        do
            sym = 8'($urandom_range(255));
        while (is_operator(sym));
        return sym;
    endfunction

    function automatic logic [7:0] random_operator();
        case ($urandom_range(3))
            0:       return SYM_PLUS;
            1:       return SYM_MINUS;
            2:       return SYM_TIMES;
            default: return SYM_SLASH;
        endcase
    endfunction

    // Mostly well-formed postfix, with broken and pure-noise expressions mixed in
    task automatic send_random_expression();
        int unsigned style;
        int unsigned operands;
        int unsigned depth;
        int unsigned length;
        logic        deep;
        style = $urandom_range(99);
        if (style < 80)
        begin
            // Rarely push past the stack depth before reducing
            deep     = ($urandom_range(59) == 0);
            operands = deep ? $urandom_range(DEPTH + 3, DEPTH - 3) : $urandom_range(8, 1);
            depth    = 0;
            while (operands > 0 || depth > 1)
            begin
                if (operands > 0 && (depth < 2 || deep || $urandom_range(1) == 1))
                begin
                    operands--;
                    depth++;
                    send_symbol(random_operand(), operands == 0 && depth == 1);
                end
                else
                begin
                    depth--;
                    send_symbol(random_operator(), operands == 0 && depth == 1);
                end
            end
        end
        else
        begin
            length = $urandom_range(8, 1);
            for (int i = 0; i < length; i++)
            begin
                if (style < 90)
                    send_symbol($urandom_range(1) ? random_operator() : random_operand(),
                                i == length - 1);
                else
                    send_symbol(8'($urandom_range(255)), i == length - 1);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Lowest and highest bytes, plus the digit range ends
    task automatic test_operand_extremes();
        send_symbol(8'd0, 1'b1);
        send_symbol(8'd255, 1'b1);
        send_symbol(SYM_ZERO, 1'b1);
        send_symbol(SYM_ZERO + 8'd9, 1'b1);
        drain_results();
    endtask

    // Each operator once, and division with both sign mixes
    task automatic test_operators();
        send_characters("73+");
        send_characters("73-");
        send_characters("73*");
        send_characters("07-2/");
        send_characters("702-/");
        drain_results();
    endtask

    // Operators with too few operands; a later error must not replace the first
    task automatic test_underflow();
        send_characters("+");
        send_characters("3-");
        send_characters("+50/");
        drain_results();
    endtask

    task automatic test_divide_by_zero();
        send_characters("50/");
        send_characters("50/++");
        drain_results();
    endtask

    // Build the most negative word as 128^4 * 8, then divide it by 0 - 1
    task automatic test_most_negative_over_minus_one();
        send_symbol(BIG_OPERAND, 1'b0);
        send_symbol(BIG_OPERAND, 1'b0);
        send_symbol(SYM_TIMES, 1'b0);
        send_symbol(BIG_OPERAND, 1'b0);
        send_symbol(SYM_TIMES, 1'b0);
        send_symbol(BIG_OPERAND, 1'b0);
        send_symbol(SYM_TIMES, 1'b0);
        send_symbol(SYM_ZERO + 8'd8, 1'b0);
        send_symbol(SYM_TIMES, 1'b0);
        send_symbol(SYM_ZERO, 1'b0);
        send_symbol(SYM_ZERO + 8'd1, 1'b0);
        send_symbol(SYM_MINUS, 1'b0);
        send_symbol(SYM_SLASH, 1'b1);
        drain_results();
    endtask

    // Fill the stack past its depth, then check the next expression starts clean
    task automatic test_overflow();
        for (int i = 0; i < DEPTH + 2; i++)
            send_symbol(SYM_ZERO + 8'd1, 1'b0);
        send_symbol(SYM_PLUS, 1'b1);
        send_characters("4");
        drain_results();
    endtask

    // Hold the result side off for a long stretch while one-character expressions keep coming
    task automatic test_back_pressure();
        int unsigned saved_pct;
        saved_pct     = send_idle_pct;
        send_idle_pct = 0;
        @(negedge clk);
        hold_left = 600;
        @(posedge clk);
        for (int i = 0; i < 150; i++)
            send_symbol(random_operand(), 1'b1);
        send_idle_pct = saved_pct;
        drain_results();
    endtask

    task automatic test_random_phase(input int unsigned sender_pct, input int unsigned
                                     receiver_pct, input int unsigned quota);
        int unsigned first;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        first         = symbols_sent;
        while (symbols_sent - first < quota)
            send_random_expression();
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Result side: pop at random and check each transaction against the oldest prediction
    // ------------------------------------------------------------------

    initial
    begin
        out_item_t expected_item;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display("[%0t] unexpected result: value %0d status %0d",
                                 $time, result.value, result.status);
                end
                else
                begin
                    expected_item = pending_results.pop_front();
                    status_tally[expected_item.status]++;
                    if (result.value !== expected_item.value
                        || result.status !== expected_item.status)
                    begin
                        fault_count++;
                        if (fault_count <= MAX_REPORTS)
                            $display({"[%0t] mismatch: value %0d (expected %0d), ",
                                      "status %0d (expected %0d)"},
                                     $time, result.value, expected_item.value,
                                     result.status, expected_item.status);
                    end
                end
            end
            // Hold pop low during a requested stall, otherwise pop at random
            if (!rst_n)
                pop <= 1'b0;
            else if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 32;
        recv_idle_pct = 81;
        test_operand_extremes();
        test_operators();
        test_underflow();
        test_divide_by_zero();
        test_most_negative_over_minus_one();
        test_overflow();
        test_back_pressure();

        test_random_phase(32, 81, 175);
        test_random_phase(81, 32, 175);
        test_random_phase(0, 0, 175);

        $display("Sent %0d characters, checked %0d expression results, input stalled %0d cycles.",
                 symbols_sent, results_seen, stall_cycles);
        $display("Statuses: %0d ok, %0d underflow, %0d overflow, %0d divide by zero.",
                 status_tally[0], status_tally[1], status_tally[2], status_tally[3]);
        if (fault_count == 0 && pending_results.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("testbench failed");
        $finish;
    end

endmodule

### postfix_expression_evaluator_top.f
design/pfe_pkg.sv
design/pfe_front.sv
design/pfe_div.sv
design/pfe_back.sv
design/postfix_expression_evaluator_top.sv
tb/testbench.sv
